// ===== design/kfc_pkg.sv =====
// Shared types and constants for the keypad four-function calculator.
// Used by kfc_front, kfc_queue, kfc_back and the top level; no dependencies.
package kfc_pkg;

    localparam int KEY_W   = 5;
    localparam int KIND_W  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);

    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 5'd9;
    localparam logic [KEY_W-1:0] KEY_DIV    = 5'd10;
    localparam logic [KEY_W-1:0] KEY_MUL    = 5'd11;
    localparam logic [KEY_W-1:0] KEY_SUB    = 5'd12;
    localparam logic [KEY_W-1:0] KEY_ADD    = 5'd13;
    localparam logic [KEY_W-1:0] KEY_EQUALS = 5'd14;
    localparam logic [KEY_W-1:0] KEY_CLEAR  = 5'd15;

    localparam logic [KIND_W-1:0] KIND_DIGIT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OPER   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EQUALS = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESULT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    // pending mark bit positions
    localparam int MARK_ADD = 0;
    localparam int MARK_SUB = 1;
    localparam int MARK_DIV = 2;
    localparam int MARK_MUL = 3;
    localparam int MARK_W   = 4;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_DIGIT  = 3'd1,
        CLS_OPER   = 3'd2,
        CLS_EQUALS = 3'd3,
        CLS_CLEAR  = 3'd4
    } t_key_class;

    typedef struct packed {
        t_key_class       cls;
        logic [KEY_W-1:0] code;
    } t_cmd;

    typedef struct packed {
        logic dividing;
        logic multiplying;
    } t_back_status;

endpackage

// ===== design/keypad_four_function_calculator.sv =====
// Keypad four-function calculator, top level: front end, command queue, back end.
// Depends on kfc_pkg, kfc_front, kfc_queue and kfc_back.
//
// Takes one decoded key code per input beat and emits display events on the
// output channel. Digit, operator and clear keys each give one event from the
// back end; equals gives its echo and then one result per pending add or
// subtract, per pending divide (one quotient bit per cycle in the restoring
// divider) and per pending multiply (product register, then write-back). A
// four-entry command queue lets keys be accepted while the back end works;
// no-key codes are accepted and dropped. Division by zero gives 0 with
// divide_by_zero set.
module keypad_four_function_calculator #(
    parameter int VALUE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [kfc_pkg::KEY_W-1:0]  i_key_code,
    output logic                       o_stall,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [kfc_pkg::KIND_W-1:0] o_event_kind,
    output logic signed [VALUE_BITS-1:0] o_event_value,
    output logic                       o_divide_by_zero,
    output logic                       o_last_of_run
);

    kfc_pkg::t_cmd         push_cmd, head_cmd;
    kfc_pkg::t_back_status back_status;
    logic                  q_push, q_pop, q_full, q_empty;
    logic [VALUE_BITS-1:0] event_value;

    kfc_front u_front (
        .i_valid    (i_valid),
        .i_key_code (i_key_code),
        .o_stall    (o_stall),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    kfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    kfc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (head_cmd),
        .i_empty          (q_empty),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_kind     (o_event_kind),
        .o_event_value    (event_value),
        .o_divide_by_zero (o_divide_by_zero),
        .o_last_of_run    (o_last_of_run),
        .o_status         (back_status)
    );

    assign o_event_value = event_value;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("command pushed into full queue");

    a_dz_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_event_kind == kfc_pkg::KIND_RESULT))
        else $error("divide_by_zero on non-result beat");

    a_single_beat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_kind == kfc_pkg::KIND_DIGIT
                  || o_event_kind == kfc_pkg::KIND_OPER
                  || o_event_kind == kfc_pkg::KIND_CLEAR)) |-> o_last_of_run)
        else $error("single-beat key without last_of_run");

    a_out_free_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_status.dividing || back_status.multiplying) |-> !o_valid)
        else $error("output held while arithmetic unit running");

endmodule

// ===== design/kfc_front.sv =====
// Front end: takes key beats, classifies them and pushes commands to the queue.
// Depends on kfc_pkg.
module kfc_front (
    input  logic                      i_valid,
    input  logic [kfc_pkg::KEY_W-1:0] i_key_code,
    output logic                      o_stall,
    input  logic                      i_full,
    output logic                      o_push,
    output kfc_pkg::t_cmd             o_cmd
);

    kfc_pkg::t_key_class cls;

    always_comb begin
        if (i_key_code <= kfc_pkg::KEY_DIGIT_MAX) begin
            cls = kfc_pkg::CLS_DIGIT;
        end else if (i_key_code >= kfc_pkg::KEY_DIV && i_key_code <= kfc_pkg::KEY_ADD) begin
            cls = kfc_pkg::CLS_OPER;
        end else if (i_key_code == kfc_pkg::KEY_EQUALS) begin
            cls = kfc_pkg::CLS_EQUALS;
        end else if (i_key_code == kfc_pkg::KEY_CLEAR) begin
            cls = kfc_pkg::CLS_CLEAR;
        end else begin
            cls = kfc_pkg::CLS_NONE;
        end
    end

    assign o_stall    = i_full;
    // no-key beats are accepted and dropped
    assign o_push     = i_valid && !i_full && (cls != kfc_pkg::CLS_NONE);
    assign o_cmd.cls  = cls;
    assign o_cmd.code = i_key_code;

endmodule

// ===== design/kfc_queue.sv =====
// Short command queue between front and back ends.
// Depends on kfc_pkg.
module kfc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kfc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output kfc_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    kfc_pkg::t_cmd r_mem [kfc_pkg::QUEUE_DEPTH];
    logic [kfc_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [kfc_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [kfc_pkg::PTR_W:0]   r_count,  n_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == (kfc_pkg::PTR_W+1)'(kfc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/kfc_back.sv =====
// Back end: executes queued commands, holds calculator state, iterative divider,
// registered multiplier and the output register. Depends on kfc_pkg.
module kfc_back #(
    parameter int VALUE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kfc_pkg::t_cmd              i_cmd,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [kfc_pkg::KIND_W-1:0] o_event_kind,
    output logic [VALUE_BITS-1:0]      o_event_value,
    output logic                       o_divide_by_zero,
    output logic                       o_last_of_run,
    output kfc_pkg::t_back_status      o_status
);

    localparam int W     = VALUE_BITS;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_APPLY = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_MUL   = 4'b1000
    } t_back_state;

    t_back_state r_state, n_state;
    logic [W-1:0]                r_entry, n_entry;
    logic [W-1:0]                r_saved, n_saved;
    logic [kfc_pkg::MARK_W-1:0]  r_marks, n_marks;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic [kfc_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [W-1:0]                r_value, n_value;
    logic                        r_dz, n_dz;
    logic                        r_last, n_last;
    logic [W-1:0]                r_rem, n_rem;
    logic [W-1:0]                r_quo, n_quo;
    logic [W-1:0]                r_den, n_den;
    logic                        r_neg, n_neg;
    logic [W-1:0]                r_prod, n_prod;

    logic         out_free;
    logic [W:0]   rem_shift, diff;
    logic         ge;
    logic [W-1:0] step_quo, step_rem;
    logic [W-1:0] code_ext;

    assign out_free  = !r_out_valid || !i_stall;
    assign code_ext  = {{(W-kfc_pkg::KEY_W){1'b0}}, i_cmd.code};

    // one restoring-division step
    assign rem_shift = {r_rem, r_quo[W-1]};
    assign diff      = rem_shift - {1'b0, r_den};
    assign ge        = !diff[W];
    assign step_quo  = {r_quo[W-2:0], ge};
    assign step_rem  = ge ? diff[W-1:0] : rem_shift[W-1:0];

    always_comb begin
        n_state     = r_state;
        n_entry     = r_entry;
        n_saved     = r_saved;
        n_marks     = r_marks;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_value     = r_value;
        n_dz        = r_dz;
        n_last      = r_last;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_den       = r_den;
        n_neg       = r_neg;
        n_prod      = r_prod;
        o_pop       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_value     = code_ext;
                    n_dz        = 1'b0;
                    n_last      = 1'b1;
                    case (i_cmd.cls)
                        kfc_pkg::CLS_DIGIT: begin
                            n_entry = (r_entry << 3) + (r_entry << 1)
                                    + {{(W-4){1'b0}}, i_cmd.code[3:0]};
                            n_kind  = kfc_pkg::KIND_DIGIT;
                        end
                        kfc_pkg::CLS_OPER: begin
                            case (i_cmd.code)
                                kfc_pkg::KEY_DIV: n_marks[kfc_pkg::MARK_DIV] = 1'b1;
                                kfc_pkg::KEY_MUL: n_marks[kfc_pkg::MARK_MUL] = 1'b1;
                                kfc_pkg::KEY_SUB: n_marks[kfc_pkg::MARK_SUB] = 1'b1;
                                default:          n_marks[kfc_pkg::MARK_ADD] = 1'b1;
                            endcase
                            n_saved = r_entry;
                            n_entry = '0;
                            n_kind  = kfc_pkg::KIND_OPER;
                        end
                        kfc_pkg::CLS_EQUALS: begin
                            n_kind = kfc_pkg::KIND_EQUALS;
                            n_last = (r_marks == '0);
                            if (r_marks != '0) begin
                                n_state = ST_APPLY;
                            end
                        end
                        kfc_pkg::CLS_CLEAR: begin
                            n_entry = '0;
                            n_marks = '0;
                            n_kind  = kfc_pkg::KIND_CLEAR;
                            n_value = '0;
                        end
                        default: begin
                            n_out_valid = r_out_valid && i_stall;
                        end
                    endcase
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    n_kind = kfc_pkg::KIND_RESULT;
                    n_dz   = 1'b0;
                    if (r_marks[kfc_pkg::MARK_ADD]) begin
                        n_marks[kfc_pkg::MARK_ADD] = 1'b0;
                        n_entry     = r_entry + r_saved;
                        n_value     = n_entry;
                        n_out_valid = 1'b1;
                        n_last      = (n_marks == '0);
                        n_state     = (n_marks == '0) ? ST_IDLE : ST_APPLY;
                    end else if (r_marks[kfc_pkg::MARK_SUB]) begin
                        n_marks[kfc_pkg::MARK_SUB] = 1'b0;
                        n_entry     = r_saved - r_entry;
                        n_value     = n_entry;
                        n_out_valid = 1'b1;
                        n_last      = (n_marks == '0);
                        n_state     = (n_marks == '0) ? ST_IDLE : ST_APPLY;
                    end else if (r_marks[kfc_pkg::MARK_DIV]) begin
                        n_marks[kfc_pkg::MARK_DIV] = 1'b0;
                        if (r_entry == '0) begin
                            n_entry     = '0;
                            n_value     = '0;
                            n_dz        = 1'b1;
                            n_out_valid = 1'b1;
                            n_last      = (n_marks == '0);
                            n_state     = (n_marks == '0) ? ST_IDLE : ST_APPLY;
                        end else begin
                            n_rem   = '0;
                            n_quo   = r_saved[W-1] ? (~r_saved + 1'b1) : r_saved;
                            n_den   = r_entry[W-1] ? (~r_entry + 1'b1) : r_entry;
                            n_neg   = r_saved[W-1] ^ r_entry[W-1];
                            n_cnt   = CNT_W'(VALUE_BITS);
                            n_state = ST_DIV;
                        end
                    end else begin
                        n_marks[kfc_pkg::MARK_MUL] = 1'b0;
                        n_prod  = r_entry * r_saved;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_DIV: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_entry     = r_neg ? (~step_quo + 1'b1) : step_quo;
                    n_kind      = kfc_pkg::KIND_RESULT;
                    n_value     = n_entry;
                    n_dz        = 1'b0;
                    n_out_valid = 1'b1;
                    n_last      = (r_marks == '0);
                    n_state     = (r_marks == '0) ? ST_IDLE : ST_APPLY;
                end
            end
            ST_MUL: begin
                n_entry     = r_prod;
                n_kind      = kfc_pkg::KIND_RESULT;
                n_value     = r_prod;
                n_dz        = 1'b0;
                n_out_valid = 1'b1;
                n_last      = (r_marks == '0);
                n_state     = (r_marks == '0) ? ST_IDLE : ST_APPLY;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_entry     <= '0;
            r_saved     <= '0;
            r_marks     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_entry     <= n_entry;
            r_saved     <= n_saved;
            r_marks     <= n_marks;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_value <= n_value;
        r_dz    <= n_dz;
        r_last  <= n_last;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_den   <= n_den;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
    end

    assign o_valid              = r_out_valid;
    assign o_event_kind         = r_kind;
    assign o_event_value        = r_value;
    assign o_divide_by_zero     = r_dz;
    assign o_last_of_run        = r_last;
    assign o_status.dividing    = (r_state == ST_DIV);
    assign o_status.multiplying = (r_state == ST_MUL);

endmodule
